@@ hw/rtl/vvpi_pkg.sv @@
// shared types, constants and state codes for the volt-var pi modulation control unit
// no dependencies
package vvpi_pkg;

	localparam int POWER_WIDTH_DEF     = 32;
	localparam int INTEG_FRAC_BITS_DEF = 16;
	localparam int AVG_DIVISOR_DEF     = 10;

	localparam int MUL_W    = 32;
	localparam int SQ_RAD_W = 62;
	localparam int SQ_ROOT_W = 31;
	localparam int DIV_NUM_W = 32;
	localparam int DIV_DEN_W = 16;
	localparam int INTEG_W  = 48;
	localparam int IDX_W    = 17;

	localparam logic [15:0] V_REF_RST     = 16'd5000;
	localparam logic [15:0] Q_KP_RST      = 16'd1024;
	localparam logic [15:0] Q_KI_RST      = 16'd256;
	localparam logic [30:0] S_RATED_RST   = 31'd1250000000;
	localparam logic [31:0] TICK_STEP_RST = 32'd357914;
	localparam logic [IDX_W-1:0] MOD_ONE  = 17'd65536;
	localparam logic [IDX_W-1:0] MOD_HALF = 17'd32768;

	typedef enum logic [2:0] {
		REG_V_REF     = 3'd0,
		REG_Q_KP      = 3'd1,
		REG_Q_KI      = 3'd2,
		REG_S_RATED   = 3'd3,
		REG_TICK_STEP = 3'd4
	} vvpi_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_BAND,
		ST_SQP,
		ST_ROOT,
		ST_ROOT_W,
		ST_CAP,
		ST_MUL_M,
		ST_MUL_P,
		ST_MUL_TLO,
		ST_MUL_THI,
		ST_INTEG,
		ST_CTRL,
		ST_MA,
		ST_DIV_MA,
		ST_AVG1,
		ST_AVG2,
		ST_AVG3,
		ST_OUT
	} vvpi_state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} vvpi_div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} vvpi_div_rsp_t;

endpackage

@@ hw/rtl/vvpi_mul.sv @@
// shared 32x32 unsigned multiplier with registered product
// depends on vvpi_pkg
module vvpi_mul import vvpi_pkg::*; (
	input  logic                 clk,
	input  logic [MUL_W-1:0]     a,
	input  logic [MUL_W-1:0]     b,
	output logic [2*MUL_W-1:0]   p
);

	logic [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
	end

	assign p = p_q;

endmodule

@@ hw/rtl/vvpi_sqrt.sv @@
// iterative integer square root, one result bit per cycle
// depends on vvpi_pkg
module vvpi_sqrt import vvpi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SQ_RAD_W-1:0]  radicand,
	output logic                 done,
	output logic [SQ_ROOT_W-1:0] root
);

	localparam int CNT_W = $clog2(SQ_ROOT_W);
	localparam int REM_W = SQ_ROOT_W + 2;

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SQ_RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [SQ_ROOT_W-1:0] root_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             fits;

	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_RAD_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQ_ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQ_RAD_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[SQ_ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ hw/rtl/vvpi_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on vvpi_pkg
module vvpi_div import vvpi_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  vvpi_div_req_t req,
	output vvpi_div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;

	logic [DIV_DEN_W:0] rem_sh;
	logic               fits;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : DIV_DEN_W'(rem_sh);
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

@@ hw/rtl/volt_var_pi_modulation_control_unit.sv @@
// inside the voltage band the held result is returned with no new computation; outside it the unit
// runs a square root and, unless the index is clamped, a division, and uses one shared multiplier
// throughput: one item at a time, next input taken the cycle after the result transfer
// reset: asynchronous active low; registers take their defaults, integrator and averages clear,
// held modulation index starts at one half
module volt_var_pi_modulation_control_unit import vvpi_pkg::*; #(
	parameter int POWER_WIDTH     = POWER_WIDTH_DEF,
	parameter int INTEG_FRAC_BITS = INTEG_FRAC_BITS_DEF,
	parameter int AVG_DIVISOR     = AVG_DIVISOR_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [15:0]                   v_pcc,
	input  logic signed [POWER_WIDTH-1:0] p_meas,
	input  logic signed [POWER_WIDTH-1:0] q_meas,
	input  logic [15:0]                   dc_voltage,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          updated,
	output logic signed [31:0]            ctrl_voltage,
	output logic [IDX_W-1:0]              mod_index,
	output logic [IDX_W-1:0]              mod_index_avg
);

	localparam int PAW = (POWER_WIDTH > 31) ? POWER_WIDTH : 31;
	localparam int CW  = PAW + 3;
	localparam int STEP_SHIFT = 40 - INTEG_FRAC_BITS;
	localparam int PROD_W = 80;
	localparam int SUM_W  = 66;
	localparam int CTRL_W = 50;
	// exact floor division by the averaging divisor for indexes below 2^IDX_W
	localparam int AVG_SHIFT = IDX_W + $clog2(AVG_DIVISOR);
	localparam int AVG_RECIP = (1 << AVG_SHIFT) / AVG_DIVISOR + 1;

	vvpi_state_t state_q, state_d;

	logic [15:0] v_ref_q, q_kp_q, q_ki_q;
	logic [30:0] s_rated_q;
	logic [31:0] tick_step_q;

	logic [15:0]                   v_q, dc_q;
	logic signed [POWER_WIDTH-1:0] qm_q;
	logic [POWER_WIDTH-1:0]        pa_q;
	logic signed [16:0]            err0_q;
	logic [SQ_RAD_W-1:0]           ssq_q;
	logic                          neg_q;
	logic [31:0]                   emag_q;
	logic [47:0]                   m_q, pmag_q;
	logic [63:0]                   acc_q;
	logic signed [INTEG_W-1:0]     integ_q;
	logic signed [31:0]            ctrl_q;
	logic [IDX_W-1:0]              ma_q, a1_q, avg_q, last_ma_q;
	logic signed [31:0]            last_ctrl_q;
	logic                          upd_q;
	logic signed [31:0]            oc_q;
	logic [IDX_W-1:0]              om_q, oa_q;

	logic [MUL_W-1:0]     mul_a, mul_b;
	logic [2*MUL_W-1:0]   mul_p;
	logic                 sq_start, sq_done;
	logic [SQ_RAD_W-1:0]  sq_rad;
	logic [SQ_ROOT_W-1:0] sq_root;
	vvpi_div_req_t        div_req;
	vvpi_div_rsp_t        div_rsp;

	vvpi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
	vvpi_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_rad),
		.done(sq_done), .root(sq_root));
	vvpi_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// band test
	logic [22:0] v100, lo99, hi101;
	logic        in_band;
	always_comb begin
		v100    = 23'(v_q) * 23'd100;
		lo99    = 23'(v_ref_q) * 23'd99;
		hi101   = 23'(v_ref_q) * 23'd101;
		in_band = !(v100 < lo99 || v100 > hi101);
	end

	// demand cap
	logic signed [CW-1:0] qsum, qdiff, ecap;
	logic signed [31:0]   e32;
	logic                 pa_le;
	always_comb begin
		pa_le = PAW'(pa_q) <= PAW'(s_rated_q);
		qsum  = CW'(qm_q) + CW'(err0_q);
		qdiff = CW'(signed'({1'b0, sq_root})) - CW'(qm_q);
		ecap  = (CW'(signed'({1'b0, sq_root})) < qsum) ? qdiff : CW'(err0_q);
		if (ecap[CW-1:31] == '0 || ecap[CW-1:31] == '1) begin
			e32 = 32'(ecap);
		end else begin
			e32 = ecap[CW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
	end

	// integrator update
	logic [PROD_W-1:0]       prod;
	logic [63:0]             step;
	logic signed [SUM_W-1:0] isum;
	logic signed [INTEG_W-1:0] integ_d;
	always_comb begin
		prod = PROD_W'(acc_q) + {mul_p[47:0], 32'd0};
		step = 64'(prod >> STEP_SHIFT);
		isum = SUM_W'(integ_q) + (neg_q ? -signed'({2'b00, step}) : signed'({2'b00, step}));
		if (isum[SUM_W-1:INTEG_W-1] == '0 || isum[SUM_W-1:INTEG_W-1] == '1) begin
			integ_d = INTEG_W'(isum);
		end else begin
			integ_d = isum[SUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
		end
	end

	// control voltage
	logic [INTEG_W-1:0]       imag;
	logic signed [CTRL_W-1:0] csum;
	logic signed [31:0]       ctrl_d;
	always_comb begin
		imag = integ_q[INTEG_W-1] ? INTEG_W'(-integ_q) : INTEG_W'(integ_q);
		csum = (neg_q ? -signed'(CTRL_W'(pmag_q >> 8)) : signed'(CTRL_W'(pmag_q >> 8)))
			+ (integ_q[INTEG_W-1] ? -signed'(CTRL_W'(imag >> INTEG_FRAC_BITS))
				: signed'(CTRL_W'(imag >> INTEG_FRAC_BITS)))
			+ signed'(CTRL_W'(v_q));
		if (csum[CTRL_W-1:31] == '0 || csum[CTRL_W-1:31] == '1) begin
			ctrl_d = 32'(csum);
		end else begin
			ctrl_d = csum[CTRL_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
	end

	logic ctrl_pos, ma_full;
	always_comb begin
		ctrl_pos = !ctrl_q[31] && (ctrl_q != 32'sd0);
		ma_full  = (dc_q == 16'd0) || (ctrl_q[30:0] >= 31'(dc_q));
	end

	// averaging quotient from the shared multiplier
	logic [IDX_W-1:0] avg_quo;
	always_comb begin
		avg_quo = IDX_W'(mul_p >> AVG_SHIFT);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mul_a       = '0;
		mul_b       = '0;
		sq_start    = 1'b0;
		sq_rad      = pa_le ? ssq_q - mul_p[SQ_RAD_W-1:0] : '0;
		div_req     = '0;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_BAND;
			end
			ST_BAND: begin
				mul_a   = 32'(s_rated_q);
				mul_b   = 32'(s_rated_q);
				state_d = in_band ? ST_OUT : ST_SQP;
			end
			ST_SQP: begin
				mul_a   = 32'(pa_q);
				mul_b   = 32'(pa_q);
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				sq_start = 1'b1;
				state_d  = ST_ROOT_W;
			end
			ST_ROOT_W: begin
				if (sq_done) state_d = ST_CAP;
			end
			ST_CAP: state_d = ST_MUL_M;
			ST_MUL_M: begin
				mul_a   = 32'(q_ki_q);
				mul_b   = emag_q;
				state_d = ST_MUL_P;
			end
			ST_MUL_P: begin
				mul_a   = emag_q;
				mul_b   = 32'(q_kp_q);
				state_d = ST_MUL_TLO;
			end
			ST_MUL_TLO: begin
				mul_a   = m_q[31:0];
				mul_b   = tick_step_q;
				state_d = ST_MUL_THI;
			end
			ST_MUL_THI: begin
				mul_a   = 32'(m_q[47:32]);
				mul_b   = tick_step_q;
				state_d = ST_INTEG;
			end
			ST_INTEG: state_d = ST_CTRL;
			ST_CTRL:  state_d = ST_MA;
			ST_MA: begin
				if (ctrl_pos && !ma_full) begin
					div_req.start = 1'b1;
					div_req.num   = {ctrl_q[15:0], 16'd0};
					div_req.den   = dc_q;
					state_d       = ST_DIV_MA;
				end else begin
					state_d = ST_AVG1;
				end
			end
			ST_DIV_MA: begin
				if (div_rsp.done) state_d = ST_AVG1;
			end
			ST_AVG1: begin
				mul_a   = MUL_W'(avg_q);
				mul_b   = MUL_W'(AVG_RECIP);
				state_d = ST_AVG2;
			end
			ST_AVG2: begin
				mul_a   = MUL_W'(ma_q);
				mul_b   = MUL_W'(AVG_RECIP);
				state_d = ST_AVG3;
			end
			ST_AVG3: state_d = ST_OUT;
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_ref_q     <= V_REF_RST;
			q_kp_q      <= Q_KP_RST;
			q_ki_q      <= Q_KI_RST;
			s_rated_q   <= S_RATED_RST;
			tick_step_q <= TICK_STEP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_V_REF:     v_ref_q     <= cfg_data[15:0];
				REG_Q_KP:      q_kp_q      <= cfg_data[15:0];
				REG_Q_KI:      q_ki_q      <= cfg_data[15:0];
				REG_S_RATED:   s_rated_q   <= cfg_data[30:0];
				REG_TICK_STEP: tick_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// held control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			avg_q       <= '0;
			last_ma_q   <= MOD_HALF;
			last_ctrl_q <= '0;
		end else begin
			if (state_q == ST_INTEG) integ_q <= integ_d;
			if (state_q == ST_AVG3) begin
				avg_q       <= avg_q - a1_q + avg_quo;
				last_ma_q   <= ma_q;
				last_ctrl_q <= ctrl_q;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					v_q  <= v_pcc;
					qm_q <= q_meas;
					dc_q <= dc_voltage;
					pa_q <= p_meas[POWER_WIDTH-1] ? POWER_WIDTH'(-p_meas) : POWER_WIDTH'(p_meas);
				end
			end
			ST_BAND: begin
				err0_q <= signed'({1'b0, v_ref_q}) - signed'({1'b0, v_q});
				if (in_band) begin
					upd_q <= 1'b0;
					oc_q  <= last_ctrl_q;
					om_q  <= last_ma_q;
					oa_q  <= avg_q;
				end
			end
			ST_SQP: ssq_q <= mul_p[SQ_RAD_W-1:0];
			ST_CAP: begin
				neg_q  <= e32[31];
				emag_q <= e32[31] ? 32'(-e32) : 32'(e32);
			end
			ST_MUL_P:   m_q    <= mul_p[47:0];
			ST_MUL_TLO: pmag_q <= mul_p[47:0];
			ST_MUL_THI: acc_q  <= mul_p;
			ST_CTRL:    ctrl_q <= ctrl_d;
			ST_MA: begin
				if (!ctrl_pos) begin
					ma_q <= '0;
				end else if (ma_full) begin
					ma_q <= MOD_ONE;
				end
			end
			ST_DIV_MA: begin
				if (div_rsp.done) ma_q <= div_rsp.quo[IDX_W-1:0];
			end
			ST_AVG2: a1_q <= avg_quo;
			ST_AVG3: begin
				upd_q <= 1'b1;
				oc_q  <= ctrl_q;
				om_q  <= ma_q;
				oa_q  <= avg_q - a1_q + avg_quo;
			end
			default: ;
		endcase
	end

	assign updated       = upd_q;
	assign ctrl_voltage  = oc_q;
	assign mod_index     = om_q;
	assign mod_index_avg = oa_q;

endmodule

@@ hw/rtl/vvpi_checker.sv @@
// port-level checks for the volt-var pi modulation control unit, bound to the top level
// depends on vvpi_pkg and volt_var_pi_modulation_control_unit
module vvpi_checker import vvpi_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          updated,
	input logic signed [31:0]            ctrl_voltage,
	input logic [IDX_W-1:0]              mod_index,
	input logic [IDX_W-1:0]              mod_index_avg
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ctrl_voltage) && $stable(mod_index)
			&& $stable(updated))
		else $error("result changed while stalled");

	// one item in flight at a time
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_no_in_with_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while result pending");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mod_index <= MOD_ONE && mod_index_avg <= MOD_ONE)
		else $error("modulation index out of range");

	a_nonpos_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && updated && (ctrl_voltage[31] || ctrl_voltage == 32'sd0)
			|-> mod_index == '0)
		else $error("nonzero index for non-positive control");

endmodule

bind volt_var_pi_modulation_control_unit vvpi_checker u_vvpi_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .updated(updated),
	.ctrl_voltage(ctrl_voltage), .mod_index(mod_index), .mod_index_avg(mod_index_avg)
);

@@ test/tb_top.sv @@
// self-checking testbench for volt_var_pi_modulation_control_unit: directed and random control ticks
// a scoreboard class predicts each result from its own copy of the registers and controller state
// depends on vvpi_pkg and the rtl of the unit
module tb_top import vvpi_pkg::*;;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SEGMENTS       = 6;
	localparam int SEG_ITEMS      = 140;

	typedef struct packed {
		logic              updated;
		logic signed [31:0] ctrl;
		logic [IDX_W-1:0]   mi;
		logic [IDX_W-1:0]   mi_avg;
	} tick_result_t;

	class vvpi_scoreboard;
		tick_result_t pending[$];
		int mismatches;
		longint unsigned v_ref, kp, ki, s_rated, t_step;
		longint integ, held_ctrl;
		longint unsigned held_mi, mi_avg;

		function new();
			v_ref = V_REF_RST; kp = Q_KP_RST; ki = Q_KI_RST;
			s_rated = S_RATED_RST; t_step = TICK_STEP_RST;
			integ = 0; held_ctrl = 0; held_mi = MOD_HALF; mi_avg = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_V_REF:     v_ref = data[15:0];
				REG_Q_KP:      kp = data[15:0];
				REG_Q_KI:      ki = data[15:0];
				REG_S_RATED:   s_rated = data[30:0];
				REG_TICK_STEP: t_step = data;
				default: ;
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function void note_input(logic [15:0] v, logic signed [31:0] p, logic signed [31:0] q,
				logic [15:0] dc);
			tick_result_t r;
			longint err, qmax, pv, qv, ctrl, prop, ipart, lim_hi, lim_lo, ihi, ilo, stp_s;
			longint unsigned pa, em, m, x, y, stp, ima, ma, vv;
			bit neg;
			vv = v;
			pv = p;
			qv = q;
			if (!(100 * vv < 99 * v_ref || 100 * vv > 101 * v_ref)) begin
				r = '{1'b0, held_ctrl[31:0], held_mi[IDX_W-1:0], mi_avg[IDX_W-1:0]};
				pending.push_back(r);
				return;
			end
			lim_hi = 64'sd2147483647;
			lim_lo = -64'sd2147483648;
			ihi = 64'sd140737488355327;
			ilo = -ihi - 1;
			err = longint'(v_ref) - longint'(vv);
			pa = (pv < 0) ? longint'(-pv) : pv;
			qmax = 0;
			if (pa <= s_rated) qmax = int_sqrt(s_rated * s_rated - pa * pa);
			if (qmax < qv + err) err = qmax - qv;
			if (err > lim_hi) err = lim_hi;
			if (err < lim_lo) err = lim_lo;
			neg = err < 0;
			em = neg ? -err : err;
			m = ki * em;
			x = m * (t_step >> 16);
			y = m * (t_step & 64'hFFFF);
			stp = (x + (y >> 16)) >> (24 - INTEG_FRAC_BITS_DEF);
			stp_s = neg ? -longint'(stp) : longint'(stp);
			integ = integ + stp_s;
			if (integ > ihi) integ = ihi;
			if (integ < ilo) integ = ilo;
			prop = (em * kp) >> 8;
			if (neg) prop = -prop;
			ima = (integ < 0) ? -integ : integ;
			ipart = ima >> INTEG_FRAC_BITS_DEF;
			if (integ < 0) ipart = -ipart;
			ctrl = prop + ipart + longint'(vv);
			if (ctrl > lim_hi) ctrl = lim_hi;
			if (ctrl < lim_lo) ctrl = lim_lo;
			if (ctrl <= 0) ma = 0;
			else if (dc == 0 || ctrl >= longint'(dc)) ma = MOD_ONE;
			else ma = (longint'(ctrl) << 16) / dc;
			mi_avg = mi_avg - mi_avg / AVG_DIVISOR_DEF + ma / AVG_DIVISOR_DEF;
			held_mi = ma;
			held_ctrl = ctrl;
			r = '{1'b1, ctrl[31:0], ma[IDX_W-1:0], mi_avg[IDX_W-1:0]};
			pending.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch %s", msg);
			mismatches++;
		endtask

		task check(tick_result_t got);
			tick_result_t want;
			if (pending.size() == 0) begin
				report("result with nothing pending");
				return;
			end
			want = pending.pop_front();
			if (got.updated !== want.updated)
				report($sformatf("updated: got %0d expected %0d", got.updated, want.updated));
			if (got.ctrl !== want.ctrl)
				report($sformatf("ctrl_voltage: got %0d expected %0d", got.ctrl, want.ctrl));
			if (got.mi !== want.mi)
				report($sformatf("mod_index: got %0d expected %0d", got.mi, want.mi));
			if (got.mi_avg !== want.mi_avg)
				report($sformatf("mod_index_avg: got %0d expected %0d", got.mi_avg, want.mi_avg));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0, in_ready;
	logic [15:0] v_pcc = '0, dc_voltage = '0;
	logic signed [31:0] p_meas = '0, q_meas = '0;
	logic out_valid, out_ready = 1'b0;
	logic updated;
	logic signed [31:0] ctrl_voltage;
	logic [IDX_W-1:0] mod_index, mod_index_avg;

	vvpi_scoreboard tick_board = new();
	int src_idle = 26, dst_idle = 86;
	int hold_req = 0;
	int quiet_cycles = 0;

	volt_var_pi_modulation_control_unit dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver with random stalls and long hold-off on request
	always @(negedge clk) begin
		if (hold_req > 0) begin
			out_ready = 1'b0;
			hold_req = hold_req - 1;
		end else begin
			out_ready = ($urandom_range(99) >= dst_idle);
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			tick_board.check('{updated, ctrl_voltage, mod_index, mod_index_avg});
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		tick_board.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_tick(logic [15:0] v, logic signed [31:0] p, logic signed [31:0] q,
			logic [15:0] dc);
		if ($urandom_range(99) < src_idle) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		v_pcc = v;
		p_meas = p;
		q_meas = q;
		dc_voltage = dc;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		tick_board.note_input(v, p, q, dc);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (tick_board.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic random_tick();
		int vr, v, r;
		logic signed [31:0] p, q;
		logic [15:0] dc;
		vr = tick_board.v_ref;
		r = $urandom_range(9);
		if (r < 5) begin
			v = vr + $urandom_range(0, vr / 25 + 4) - (vr / 50 + 2);
			if (v < 0) v = 0;
			if (v > 65535) v = 65535;
		end else begin
			v = $urandom_range(65535);
		end
		if ($urandom_range(1)) p = $urandom_range(tick_board.s_rated) * ($urandom_range(1) ? 1 : -1);
		else p = $urandom;
		if ($urandom_range(1)) q = $urandom;
		else q = $signed(32'($urandom_range(200000))) - 100000;
		r = $urandom_range(9);
		dc = (r == 0) ? 16'd0 : (r < 5) ? 16'($urandom_range(65535)) : 16'($urandom_range(v + 100));
		send_tick(v[15:0], p, q, dc);
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed ticks with reset register values
		send_tick(16'd5000, 32'sd0, 32'sd0, 16'd6000);
		send_tick(16'd0, 32'sd0, 32'sd0, 16'd6000);
		send_tick(16'd65535, 32'sd0, 32'sd0, 16'd1);
		send_tick(16'd4900, 32'sd0, 32'sd0, 16'd0);
		send_tick(16'd5050, 32'sd0, 32'sd0, 16'd5000);
		send_tick(16'd4949, -32'sd2147483648, 32'sd0, 16'd65535);
		send_tick(16'd5051, 32'sd2147483647, 32'sd2147483647, 16'd65535);
		send_tick(16'd1000, 32'sd1250000000, -32'sd2147483648, 16'd2000);
		send_tick(16'd1000, 32'sd1250000001, 32'sd0, 16'd2000);
		send_tick(16'd30000, -32'sd5, 32'sd2147483647, 16'd0);
		send_tick(16'd65535, 32'sd0, -32'sd2147483648, 16'd65535);
		send_tick(16'd4990, 32'sd100, 32'sd100, 16'd5000);
		send_tick(16'd5010, -32'sd1, -32'sd1, 16'd5000);
		send_tick(16'd1, 32'sd0, 32'sd0, 16'd1);
		send_tick(16'd6000, 32'sd0, 32'sd0, 16'd3000);
		send_tick(16'd4000, 32'sd0, 32'sd0, 16'd65535);
		drain();

		for (int s = 0; s < SEGMENTS; s++) begin
			src_idle = (s < 2) ? 26 : (s < 4) ? 86 : 0;
			dst_idle = (s < 2) ? 86 : (s < 4) ? 26 : 0;
			if (s == 0) begin
				write_reg(REG_V_REF, 32'hFFFF);
				write_reg(REG_Q_KP, 32'hFFFF);
				write_reg(REG_Q_KI, 32'hFFFF);
				write_reg(REG_S_RATED, 32'h7FFFFFFF);
				write_reg(REG_TICK_STEP, 32'hFFFFFFFF);
			end else if (s == 1) begin
				write_reg(REG_V_REF, 32'h0);
				write_reg(REG_Q_KP, 32'h0);
				write_reg(REG_Q_KI, 32'h0);
				write_reg(REG_S_RATED, 32'h0);
				write_reg(REG_TICK_STEP, 32'h0);
			end else begin
				write_reg(REG_V_REF, $urandom_range(1000, 60000));
				write_reg(REG_Q_KP, $urandom);
				write_reg(REG_Q_KI, $urandom);
				write_reg(REG_S_RATED, $urandom);
				write_reg(REG_TICK_STEP, $urandom);
			end
			write_reg(3'(REG_TICK_STEP) + 3'($urandom_range(1, 3)), $urandom);
			if (s == 2) hold_req = 500;
			for (int i = 0; i < SEG_ITEMS; i++) random_tick();
			drain();
		end

		repeat (200) @(posedge clk);
		if (tick_board.mismatches == 0 && tick_board.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/vvpi_pkg.sv
hw/rtl/vvpi_mul.sv
hw/rtl/vvpi_sqrt.sv
hw/rtl/vvpi_div.sv
hw/rtl/volt_var_pi_modulation_control_unit.sv
hw/rtl/vvpi_checker.sv
test/tb_top.sv
